>>> hdl/touch_slot_event_generator_assert.svh
// Assertion macros used by the checker of the touch slot event generator.
`ifndef TOUCH_SLOT_EVENT_GENERATOR_ASSERT_SVH
`define TOUCH_SLOT_EVENT_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSEG_ASSERT_SAME(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSEG_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tseg_pkg.sv
// Types and constants shared by the touch slot event generator modules.
package tseg_pkg;

  localparam int FIELD_BITS = 12;

  localparam logic [1:0] KIND_REPORT  = 2'd0;
  localparam logic [1:0] KIND_CONSUME = 2'd1;
  localparam logic [1:0] KIND_INJECT  = 2'd2;

  localparam logic [1:0] PHASE_DOWN = 2'd0;
  localparam logic [1:0] PHASE_MOVE = 2'd1;
  localparam logic [1:0] PHASE_UP   = 2'd2;

  localparam logic [1:0] EV_DOWN     = 2'd0;
  localparam logic [1:0] EV_MOVE     = 2'd1;
  localparam logic [1:0] EV_UP       = 2'd2;
  localparam logic [1:0] EV_READBACK = 2'd3;

  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MULTI   = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PRIMARY = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = PTR_BITS + 1;

  typedef struct packed {
    logic [1:0]            kind;
    logic [1:0]            contact_count;
    logic [FIELD_BITS-1:0] first_x;
    logic [FIELD_BITS-1:0] first_y;
    logic [FIELD_BITS-1:0] second_x;
    logic [FIELD_BITS-1:0] second_y;
    logic [1:0]            inject_phase;
    logic                  inject_touching;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            event_type;
    logic                  touching;
    logic [FIELD_BITS-1:0] pos_x;
    logic [FIELD_BITS-1:0] pos_y;
    logic                  pointer_id;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    logic multi;
    logic primary;
  } route_cfg_t;

  typedef struct packed {
    logic down;
    logic move;
    logic up;
  } slot_status_t;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } result_set_t;

endpackage

>>> hdl/touch_slot_event_generator.sv
// Touch slot event generator: one transaction per clock is accepted into an input
// register, its Down, Move, Up or readback results are formed in the next cycle from
// the slot and latest-move state and written into a four-entry result queue for the
// output, which delivers one result per cycle while out_stall is low, so the results
// of a report that changes both slots leave one after the other; the input stalls
// only while the queue has no room for all results of the registered transaction.
module touch_slot_event_generator
  import tseg_pkg::*;
#(
  parameter int SLOT_COUNT = 2,
  parameter int COORD_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_item_t                 out_data,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  route_cfg_t          route;
  in_item_t            item;
  logic                item_valid;
  logic                fire;
  logic [CNT_BITS-1:0] free;
  result_set_t         results;
  logic [SLOT_COUNT-1:0] slot_now;
  logic                slot_update;
  slot_status_t        slot_status [SLOT_COUNT];
  logic [COORD_BITS-1:0] slot_x [SLOT_COUNT];
  logic [COORD_BITS-1:0] slot_y [SLOT_COUNT];

  assign fire     = item_valid && (free >= CNT_BITS'(results.count));
  assign in_stall = item_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      route <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MULTI:   route.multi   <= cfg_data[0];
        REG_PRIMARY: route.primary <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_slot
    logic [COORD_BITS-1:0] x_in;
    logic [COORD_BITS-1:0] y_in;

    if (s == 0) begin : g_first
      assign x_in = COORD_BITS'(item.first_x);
      assign y_in = COORD_BITS'(item.first_y);
    end else begin : g_other
      assign x_in = COORD_BITS'(item.second_x);
      assign y_in = COORD_BITS'(item.second_y);
    end

    tseg_slot #(
      .CW(COORD_BITS)
    ) u_slot (
      .clk    (clk),
      .rst    (rst),
      .update (slot_update),
      .now    (slot_now[s]),
      .x      (x_in),
      .y      (y_in),
      .status (slot_status[s]),
      .ev_x   (slot_x[s]),
      .ev_y   (slot_y[s])
    );
  end

  tseg_event_logic #(
    .SLOT_COUNT(SLOT_COUNT),
    .CW        (COORD_BITS)
  ) u_event_logic (
    .clk         (clk),
    .rst         (rst),
    .route       (route),
    .item        (item),
    .fire        (fire),
    .slot_now    (slot_now),
    .slot_update (slot_update),
    .slot_status (slot_status),
    .slot_x      (slot_x),
    .slot_y      (slot_y),
    .results     (results)
  );

  tseg_result_fifo u_result_fifo (
    .clk         (clk),
    .rst         (rst),
    .push_count  (fire ? results.count : 2'd0),
    .push_first  (results.first),
    .push_second (results.second),
    .free        (free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

>>> hdl/tseg_slot.sv
// One pointer slot: active flag, held position and its transition detection.
module tseg_slot
  import tseg_pkg::*;
#(
  parameter int CW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          update,
  input  logic          now,
  input  logic [CW-1:0] x,
  input  logic [CW-1:0] y,
  output slot_status_t  status,
  output logic [CW-1:0] ev_x,
  output logic [CW-1:0] ev_y
);

  logic          active;
  logic [CW-1:0] pos_x;
  logic [CW-1:0] pos_y;

  always_comb begin
    status.down = now && !active;
    status.move = now && active && ((x != pos_x) || (y != pos_y));
    status.up   = !now && active;
    ev_x        = now ? x : pos_x;
    ev_y        = now ? y : pos_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pos_x  <= '0;
      pos_y  <= '0;
    end else if (update) begin
      active <= now;
      if (now) begin
        pos_x <= x;
        pos_y <= y;
      end
    end
  end

endmodule

>>> hdl/tseg_event_logic.sv
// Event formation, routing filter and coalesced primary move state.
module tseg_event_logic
  import tseg_pkg::*;
#(
  parameter int SLOT_COUNT = 2,
  parameter int CW         = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  route_cfg_t           route,
  input  in_item_t             item,
  input  logic                 fire,
  output logic [SLOT_COUNT-1:0] slot_now,
  output logic                 slot_update,
  input  slot_status_t         slot_status [SLOT_COUNT],
  input  logic [CW-1:0]        slot_x [SLOT_COUNT],
  input  logic [CW-1:0]        slot_y [SLOT_COUNT],
  output result_set_t          results
);

  logic [1:0]    cnt;
  logic [CW-1:0] px0;
  logic [CW-1:0] py0;
  logic          route0;
  logic          route1;
  logic [CW-1:0] latest_x;
  logic [CW-1:0] latest_y;
  logic          queued;
  logic [CW-1:0] latest_x_next;
  logic [CW-1:0] latest_y_next;
  logic          queued_next;
  out_item_t     a;
  out_item_t     b;
  logic          a_v;
  logic          b_v;
  out_item_t     b1;
  logic          b1_v;

  assign cnt = (item.contact_count > 2'(SLOT_COUNT)) ? 2'(SLOT_COUNT) : item.contact_count;
  assign px0 = CW'(item.first_x);
  assign py0 = CW'(item.first_y);
  assign route0 = route.multi || route.primary;
  assign route1 = route.multi;
  assign slot_update = fire && (item.kind == KIND_REPORT);

  for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_now
    assign slot_now[s] = cnt > 2'(s);
  end

  if (SLOT_COUNT > 1) begin : g_second
    always_comb begin
      b1            = '0;
      b1.pointer_id = 1'b1;
      b1.pos_x      = FIELD_BITS'(slot_x[1]);
      b1.pos_y      = FIELD_BITS'(slot_y[1]);
      b1_v          = route1 && (slot_status[1].down || slot_status[1].move ||
                                 slot_status[1].up);
      if (slot_status[1].down) begin
        b1.event_type = EV_DOWN;
        b1.touching   = 1'b1;
      end else if (slot_status[1].move) begin
        b1.event_type = EV_MOVE;
        b1.touching   = 1'b1;
      end else begin
        b1.event_type = EV_UP;
        b1.touching   = 1'b0;
      end
    end
  end else begin : g_single
    assign b1   = '0;
    assign b1_v = 1'b0;
  end

  always_comb begin
    a   = '0;
    b   = '0;
    a_v = 1'b0;
    b_v = 1'b0;
    case (item.kind)
      KIND_REPORT: begin
        a.pos_x = FIELD_BITS'(slot_x[0]);
        a.pos_y = FIELD_BITS'(slot_y[0]);
        if (slot_status[0].down) begin
          a.event_type = EV_DOWN;
          a.touching   = 1'b1;
          a_v          = route0;
        end else if (slot_status[0].move) begin
          a.event_type = EV_MOVE;
          a.touching   = 1'b1;
          a_v          = route0 && !queued;
        end else if (slot_status[0].up) begin
          a.event_type = EV_UP;
          a.touching   = 1'b0;
          a_v          = route0;
        end
        b   = b1;
        b_v = b1_v;
      end
      KIND_CONSUME: begin
        a.event_type = EV_READBACK;
        a.pos_x      = FIELD_BITS'(latest_x);
        a.pos_y      = FIELD_BITS'(latest_y);
        a_v          = 1'b1;
      end
      KIND_INJECT: begin
        a.pos_x = FIELD_BITS'(px0);
        a.pos_y = FIELD_BITS'(py0);
        if (item.inject_phase == PHASE_MOVE) begin
          a.event_type = EV_MOVE;
          a.touching   = 1'b1;
          a_v          = route0 && !queued;
        end else if ((item.inject_phase == PHASE_DOWN) || (item.inject_phase == PHASE_UP)) begin
          a.event_type = item.inject_phase;
          a.touching   = item.inject_touching;
          a_v          = route0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    results.count       = {1'b0, a_v} + {1'b0, b_v};
    results.first       = a_v ? a : b;
    results.first.last  = !(a_v && b_v);
    results.second      = b;
    results.second.last = 1'b1;
  end

  always_comb begin
    latest_x_next = latest_x;
    latest_y_next = latest_y;
    queued_next   = queued;
    if (fire) begin
      case (item.kind)
        KIND_REPORT: begin
          if (slot_status[0].down || slot_status[0].move) begin
            latest_x_next = slot_x[0];
            latest_y_next = slot_y[0];
          end
          if (slot_status[0].move) begin
            queued_next = 1'b1;
          end
        end
        KIND_CONSUME: begin
          queued_next = 1'b0;
        end
        KIND_INJECT: begin
          if (item.inject_phase == PHASE_MOVE) begin
            latest_x_next = px0;
            latest_y_next = py0;
            queued_next   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latest_x <= '0;
      latest_y <= '0;
      queued   <= 1'b0;
    end else begin
      latest_x <= latest_x_next;
      latest_y <= latest_y_next;
      queued   <= queued_next;
    end
  end

endmodule

>>> hdl/tseg_result_fifo.sv
// Result queue that takes up to two results per cycle and delivers one while out_stall is low.
module tseg_result_fifo
  import tseg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_count,
  input  out_item_t           push_first,
  input  out_item_t           push_second,
  output logic [CNT_BITS-1:0] free,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data
);

  out_item_t           mem [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] wr_ptr_inc;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                pop;

  assign wr_ptr_inc = wr_ptr + PTR_BITS'(1);
  assign out_valid  = count != '0;
  assign out_data   = mem[rd_ptr];
  assign pop        = out_valid && !out_stall;
  assign free       = CNT_BITS'(FIFO_DEPTH) - count;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push_first;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr_inc] <= push_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push_count);
      rd_ptr <= rd_ptr + PTR_BITS'(pop);
      count  <= count + CNT_BITS'(push_count) - CNT_BITS'(pop);
    end
  end

endmodule

>>> hdl/tseg_checker.sv
// Port-level checker for the touch slot event generator and its bind.
`include "touch_slot_event_generator_assert.svh"

module tseg_checker
  import tseg_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  `TSEG_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid && !in_stall, "not empty after reset")
  `TSEG_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `TSEG_ASSERT_SAME(a_readback_form, clk, rst, out_valid && (out_data.event_type == EV_READBACK), out_data.last && !out_data.touching && !out_data.pointer_id, "malformed readback")
  `TSEG_ASSERT_SAME(a_second_slot_last, clk, rst, out_valid && out_data.pointer_id, out_data.last, "second slot event not last of its transaction")

endmodule

bind touch_slot_event_generator tseg_checker u_tseg_checker (.*);
